// ===== sv/hcs_pkg.sv =====
// Shared codes, tables and status types for the Hall commutation sequencer.
package hcs_pkg;

    // Hall phase codes; the fourth code doubles as "any phase" in the arming state
    localparam logic [1:0] PHASE_U   = 2'd0;
    localparam logic [1:0] PHASE_V   = 2'd1;
    localparam logic [1:0] PHASE_W   = 2'd2;
    localparam logic [1:0] PHASE_ANY = 2'd3;

    // Event kinds carried in the input tuser
    localparam logic EVT_HALL    = 1'b0;
    localparam logic EVT_COMPARE = 1'b1;

    // Motor modes
    localparam logic [1:0] MODE_STOPPED   = 2'd0;
    localparam logic [1:0] MODE_FORCED    = 2'd1;
    localparam logic [1:0] MODE_AUTO_FREE = 2'd2;
    localparam logic [1:0] MODE_AUTO_PID  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_MOTOR_MODE     = 2'd0;
    localparam logic [1:0] REG_FORCE_INTERVAL = 2'd1;

    localparam logic [2:0] STEP_LAST = 3'd5;

    // Arming and commutation state
    typedef struct packed {
        logic [2:0] step_index;
        logic [1:0] armed_phase;
        logic       armed_rising;
    } hcs_arm_t;

    // Per-word status carried from the step logic to the result register
    typedef struct packed {
        logic       interval_valid;
        logic [1:0] interval_phase;
        logic [2:0] comm_step;
        logic       commutate;
        logic       accepted;
    } hcs_flags_t;

    // Advance a commutation step modulo six
    function automatic logic [2:0] step_advance(input logic [2:0] step);
        return (step >= STEP_LAST) ? 3'd0 : step + 3'd1;
    endfunction

    // Fixed step for an accepted edge: U rise 0, W fall 1, V rise 2, U fall 3, W rise 4, V fall 5
    function automatic logic [2:0] step_for_edge(input logic [1:0] phase, input logic rising);
        logic [2:0] step;
        step = 3'd0;
        case (phase)
            PHASE_U: step = rising ? 3'd0 : 3'd3;
            PHASE_V: step = rising ? 3'd2 : 3'd5;
            PHASE_W: step = rising ? 3'd4 : 3'd1;
            default: step = 3'd0;
        endcase
        return step;
    endfunction

    // Phase armed after an edge: U then W, W then V, V then U
    function automatic logic [1:0] phase_after(input logic [1:0] phase);
        logic [1:0] nxt;
        nxt = PHASE_ANY;
        case (phase)
            PHASE_U: nxt = PHASE_W;
            PHASE_V: nxt = PHASE_U;
            PHASE_W: nxt = PHASE_V;
            default: nxt = PHASE_ANY;
        endcase
        return nxt;
    endfunction

endpackage

// ===== sv/hcs_step.sv =====
// Combinational update of the sequencer state for one event word.
module hcs_step #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                   mode,
    input  logic [1:0]             hall_phase,
    input  logic                   edge_rising,
    input  logic [TIMER_WIDTH-1:0] capture_time,
    input  logic [1:0]             motor_mode,
    input  logic [TIMER_WIDTH-1:0] force_interval,
    input  hcs_pkg::hcs_arm_t      arm,
    input  logic [TIMER_WIDTH-1:0] last_capture [3],
    input  logic [TIMER_WIDTH-1:0] compare_time,
    output hcs_pkg::hcs_arm_t      arm_next,
    output hcs_pkg::hcs_flags_t    flags,
    output logic                   capture_we,
    output logic [TIMER_WIDTH-1:0] edge_interval,
    output logic [TIMER_WIDTH-1:0] compare_next
);

    logic [TIMER_WIDTH-1:0] prev_capture;
    logic                   edge_match;

    always_comb
    begin
        case (hall_phase)
            hcs_pkg::PHASE_U: prev_capture = last_capture[0];
            hcs_pkg::PHASE_V: prev_capture = last_capture[1];
            hcs_pkg::PHASE_W: prev_capture = last_capture[2];
            default:          prev_capture = '0;
        endcase
    end

    assign edge_match = (hall_phase != hcs_pkg::PHASE_ANY) &&
                        ((arm.armed_phase == hcs_pkg::PHASE_ANY) ||
                         ((hall_phase == arm.armed_phase) && (edge_rising == arm.armed_rising)));

    always_comb
    begin
        arm_next      = arm;
        flags         = '0;
        capture_we    = 1'b0;
        edge_interval = '0;
        compare_next  = compare_time;
        if (mode == hcs_pkg::EVT_COMPARE)
        begin
            flags.accepted = 1'b1;
            compare_next   = compare_time + force_interval;
            if (motor_mode == hcs_pkg::MODE_FORCED)
            begin
                arm_next.step_index = hcs_pkg::step_advance(arm.step_index);
                flags.commutate     = 1'b1;
            end
        end
        else if (edge_match)
        begin
            flags.accepted = 1'b1;
            if (motor_mode inside {hcs_pkg::MODE_AUTO_FREE, hcs_pkg::MODE_AUTO_PID})
            begin
                arm_next.step_index = hcs_pkg::step_for_edge(hall_phase, edge_rising);
                flags.commutate     = 1'b1;
            end
            arm_next.armed_phase  = hcs_pkg::phase_after(hall_phase);
            arm_next.armed_rising = ~edge_rising;
            edge_interval         = capture_time - prev_capture;
            capture_we            = 1'b1;
            flags.interval_phase  = hall_phase;
            flags.interval_valid  = 1'b1;
        end
        flags.comm_step = arm_next.step_index;
    end

endmodule

// ===== sv/hall_commutation_sequencer.sv =====
// Top level of the Hall sensor six-step commutation sequencer.
//
//  channel | direction | handshake               | contents
//  --------+-----------+-------------------------+-------------------------------------------
//  s_*     | in        | s_tvalid / s_tready     | event word: kind in tuser, edge in tdata
//  m_*     | out       | m_tvalid / m_tready     | result word: status, step, interval
//  cfg_*   | in        | cfg_valid / cfg_ready   | register write: index and data
//
// Every event word yields exactly one result word. A word waits in the
// input register, where the step logic updates the state, then sits in the result
// register until taken; a new word is taken every cycle while the result moves on.
// m_tvalid is registered, so a result is offered only after the word has passed
// through both the input register and the result register.
// Reset clears the state to step 0, any phase armed, captures and compare time zero.
// A stall on m_tready holds the result and, once the input register is full, drops
// s_tready. Configuration writes are always taken (cfg_ready is tied high).
module hall_commutation_sequencer #(
    parameter int TIMER_WIDTH = 16,
    localparam int IN_FIELDS_W  = 3 + TIMER_WIDTH,
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8,
    localparam int OUT_FIELDS_W = 7 + 2 * TIMER_WIDTH,
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // tuser: [0] mode
    input  logic                    s_tuser,
    // tdata: hall_phase, edge_rising, capture_time, zero pad
    input  logic [IN_DATA_W-1:0]    s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // tuser: [0] interval_valid
    output logic                    m_tuser,
    // tdata: accepted, commutate, comm_step, interval_phase, edge_interval,
    //        next_compare, zero pad
    output logic [OUT_DATA_W-1:0]   m_tdata,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [TIMER_WIDTH-1:0]  cfg_data
);

    // Configuration registers
    logic [1:0]             motor_mode_reg;
    logic [TIMER_WIDTH-1:0] force_interval_reg;

    // Sequencer state
    hcs_pkg::hcs_arm_t      arm_reg;
    logic [TIMER_WIDTH-1:0] last_capture_reg [3];
    logic [TIMER_WIDTH-1:0] compare_time_reg;

    // Input register
    logic                   in_valid_reg;
    logic                   in_mode_reg;
    logic [1:0]             in_phase_reg;
    logic                   in_rising_reg;
    logic [TIMER_WIDTH-1:0] in_capture_reg;

    // Result register
    logic                   out_valid_reg;
    hcs_pkg::hcs_flags_t    out_flags_reg;
    logic [TIMER_WIDTH-1:0] out_interval_reg;
    logic [TIMER_WIDTH-1:0] out_compare_reg;

    // Step logic outputs
    hcs_pkg::hcs_arm_t      arm_next;
    hcs_pkg::hcs_flags_t    flags_next;
    logic                   capture_we;
    logic [TIMER_WIDTH-1:0] interval_next;
    logic [TIMER_WIDTH-1:0] compare_next;

    logic                   in_take;
    logic                   advance;

    // Advance the held word once the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_mode_reg     <= hcs_pkg::MODE_STOPPED;
            force_interval_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                hcs_pkg::REG_MOTOR_MODE:     motor_mode_reg     <= cfg_data[1:0];
                hcs_pkg::REG_FORCE_INTERVAL: force_interval_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // Input register: hold the word until the step logic consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take || advance)
        begin
            in_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_mode_reg    <= s_tuser;
            in_phase_reg   <= s_tdata[1:0];
            in_rising_reg  <= s_tdata[2];
            in_capture_reg <= s_tdata[IN_FIELDS_W-1:3];
        end
    end

    hcs_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .mode           (in_mode_reg),
        .hall_phase     (in_phase_reg),
        .edge_rising    (in_rising_reg),
        .capture_time   (in_capture_reg),
        .motor_mode     (motor_mode_reg),
        .force_interval (force_interval_reg),
        .arm            (arm_reg),
        .last_capture   (last_capture_reg),
        .compare_time   (compare_time_reg),
        .arm_next       (arm_next),
        .flags          (flags_next),
        .capture_we     (capture_we),
        .edge_interval  (interval_next),
        .compare_next   (compare_next)
    );

    // State update: commit only when the word moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_reg.step_index   <= 3'd0;
            arm_reg.armed_phase  <= hcs_pkg::PHASE_ANY;
            arm_reg.armed_rising <= 1'b0;
            last_capture_reg[0]  <= '0;
            last_capture_reg[1]  <= '0;
            last_capture_reg[2]  <= '0;
            compare_time_reg     <= '0;
        end
        else if (advance)
        begin
            arm_reg          <= arm_next;
            compare_time_reg <= compare_next;
            if (capture_we)
            begin
                case (in_phase_reg)
                    hcs_pkg::PHASE_U: last_capture_reg[0] <= in_capture_reg;
                    hcs_pkg::PHASE_V: last_capture_reg[1] <= in_capture_reg;
                    hcs_pkg::PHASE_W: last_capture_reg[2] <= in_capture_reg;
                    default:          ;
                endcase
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_flags_reg    <= flags_next;
            out_interval_reg <= interval_next;
            out_compare_reg  <= compare_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_flags_reg.interval_valid;
    assign m_tdata  = OUT_DATA_W'({out_compare_reg, out_interval_reg,
                                   out_flags_reg.interval_phase, out_flags_reg.comm_step,
                                   out_flags_reg.commutate, out_flags_reg.accepted});

    // A fresh interval only ever comes with an accepted edge
    a_interval_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tuser || m_tdata[0]))
        else $error("interval reported for a word that was not accepted");

    // A commutation is only reported for an accepted word
    a_commutate_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[1] || m_tdata[0]))
        else $error("commutation without acceptance");

    // The step index stays within the six-step cycle
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        arm_reg.step_index <= hcs_pkg::STEP_LAST)
        else $error("commutation step out of range");

    // Backpressure only when both the input and the result register are occupied
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without a full pipeline");

endmodule

// ===== tb/hcs_commutation_checker.sv =====
`timescale 1ns / 100ps
// Checker for the Hall commutation sequencer: predicts every result word and compares it.
module hcs_commutation_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        s_tuser,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        m_tuser,
    input  logic [39:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    typedef struct packed {
        logic        accepted;
        logic        commutate;
        logic [2:0]  comm_step;
        logic [1:0]  interval_phase;
        logic [15:0] edge_interval;
        logic        interval_valid;
        logic [15:0] next_compare;
    } outcome_t;

    outcome_t    outcome_q[$];
    outcome_t    want;
    int          fails = 0;
    int          seen = 0;
    int          held = 0;

    // Shadow copy of the configuration and the sequencing state
    logic [1:0]  motor_mode;
    logic [15:0] force_interval;
    logic [2:0]  step;
    logic [1:0]  armed_ph;
    logic        armed_rise;
    logic [15:0] last_cap [3];
    logic [15:0] compare_time;

    assign fail_count = fails;
    assign pending    = held;
    assign checked    = seen;

    // Work out the result of one event word and advance the shadow state
    function automatic outcome_t commutation_outcome(input logic evt, input logic [1:0] ph,
                                                     input logic rise, input logic [15:0] cap);
        outcome_t o;
        o = '0;
        if (evt == hcs_pkg::EVT_COMPARE)
        begin
            o.accepted   = 1'b1;
            compare_time = compare_time + force_interval;
            if (motor_mode == hcs_pkg::MODE_FORCED)
            begin
                step        = (step >= 3'd5) ? 3'd0 : step + 3'd1;
                o.commutate = 1'b1;
            end
        end
        else if (ph != hcs_pkg::PHASE_ANY &&
                 (armed_ph == hcs_pkg::PHASE_ANY || (ph == armed_ph && rise == armed_rise)))
        begin
            o.accepted = 1'b1;
            if (motor_mode == hcs_pkg::MODE_AUTO_FREE || motor_mode == hcs_pkg::MODE_AUTO_PID)
            begin
                case (ph)
                    hcs_pkg::PHASE_U: step = rise ? 3'd0 : 3'd3;
                    hcs_pkg::PHASE_V: step = rise ? 3'd2 : 3'd5;
                    default:          step = rise ? 3'd4 : 3'd1;
                endcase
                o.commutate = 1'b1;
            end
            case (ph)
                hcs_pkg::PHASE_U: armed_ph = hcs_pkg::PHASE_W;
                hcs_pkg::PHASE_V: armed_ph = hcs_pkg::PHASE_U;
                default:          armed_ph = hcs_pkg::PHASE_V;
            endcase
            armed_rise       = ~rise;
            o.edge_interval  = cap - last_cap[ph];
            last_cap[ph]     = cap;
            o.interval_phase = ph;
            o.interval_valid = 1'b1;
        end
        o.comm_step    = step;
        o.next_compare = compare_time;
        return o;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] exp_val,
                                 input logic [15:0] got_val);
        if (exp_val !== got_val)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_val, got_val);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_mode     = hcs_pkg::MODE_STOPPED;
            force_interval = '0;
            step           = '0;
            armed_ph       = hcs_pkg::PHASE_ANY;
            armed_rise     = 1'b0;
            last_cap[0]    = '0;
            last_cap[1]    = '0;
            last_cap[2]    = '0;
            compare_time   = '0;
            outcome_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hcs_pkg::REG_MOTOR_MODE:     motor_mode = cfg_data[1:0];
                    hcs_pkg::REG_FORCE_INTERVAL: force_interval = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                outcome_q.push_back(commutation_outcome(s_tuser, s_tdata[1:0], s_tdata[2],
                                                        s_tdata[18:3]));
            if (m_tvalid && m_tready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: result word %0h with no event pending", $time, m_tdata);
                    fails++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    compare_field("accepted", want.accepted, m_tdata[0]);
                    compare_field("commutate", want.commutate, m_tdata[1]);
                    compare_field("comm_step", want.comm_step, m_tdata[4:2]);
                    compare_field("interval_phase", want.interval_phase, m_tdata[6:5]);
                    compare_field("edge_interval", want.edge_interval, m_tdata[22:7]);
                    compare_field("next_compare", want.next_compare, m_tdata[38:23]);
                    compare_field("interval_valid", want.interval_valid, m_tuser);
                    seen++;
                end
            end
        end
        held = outcome_q.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the Hall commutation sequencer: clock, reset, stimulus and verdict.
module tb;

    localparam int RANDOM_WORDS = 190;   // per register setting, eight settings
    localparam int LONG_HOLD    = 300;   // receiver hold-off, long enough to fill the block
    localparam int TIMEOUT_NS   = 2_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // tuser: [0] mode
    logic        s_tuser = 1'b0;
    // tdata: [1:0] hall_phase, [2] edge_rising, [18:3] capture_time, [23:19] zero
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // tuser: [0] interval_valid
    logic        m_tuser;
    // tdata: [0] accepted, [1] commutate, [4:2] comm_step, [6:5] interval_phase,
    //        [22:7] edge_interval, [38:23] next_compare, [39] zero
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int          fail_count;
    int          pending;
    int          checked;

    // Idling profile, in percent of cycles
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;

    // Long hold-off request: the receiver acts whenever the toggle changes
    logic        hold_tog = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;

    // Edge the sequencer is expected to accept next, used to shape well-formed runs
    logic        track_any = 1'b1;
    logic [1:0]  track_ph = hcs_pkg::PHASE_U;
    logic        track_rise = 1'b0;

    int          words_sent = 0;

    hall_commutation_sequencer #(
        .TIMER_WIDTH (16)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hcs_commutation_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: stall at random, or hold off for a long stretch when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_tog != hold_seen)
            begin
                hold_seen = hold_tog;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Offer one event word, idling first at random, and hold it until taken.
    // Leave tvalid high so that the next word can follow without a gap.
    task automatic send_word(input logic evt, input logic [1:0] ph, input logic rise,
                             input logic [15:0] cap);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= evt;
        s_tdata  <= {5'd0, cap, rise, ph};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
        // Follow the arming so that the random part can stay on the expected edge
        if (evt == hcs_pkg::EVT_HALL && ph != hcs_pkg::PHASE_ANY &&
            (track_any || (ph == track_ph && rise == track_rise)))
        begin
            track_any  = 1'b0;
            track_ph   = (ph == hcs_pkg::PHASE_U) ? hcs_pkg::PHASE_W :
                         (ph == hcs_pkg::PHASE_W) ? hcs_pkg::PHASE_V : hcs_pkg::PHASE_U;
            track_rise = ~rise;
        end
    endtask

    // Drop tvalid and hold until every expected result word has come back
    task automatic wait_results_drained;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Write both registers back to back, then release the channel
    task automatic program_regs(input logic [1:0] mode, input logic [15:0] fint);
        cfg_valid <= 1'b1;
        cfg_index <= hcs_pkg::REG_MOTOR_MODE;
        cfg_data  <= {14'd0, mode};
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= hcs_pkg::REG_FORCE_INTERVAL;
        cfg_data  <= fint;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed Hall sequences with random timing, some compare events,
    // and some stray or malformed edges as noise
    task automatic random_words(input int count);
        int          pick;
        int          cap_pick;
        logic        evt;
        logic [1:0]  ph;
        logic        rise;
        logic [15:0] cap;
        for (int i = 0; i < count; i++)
        begin
            pick     = $urandom_range(0, 99);
            cap_pick = $urandom_range(0, 19);
            cap      = (cap_pick == 0) ? 16'h0000 :
                       (cap_pick == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            if (pick < 72)
            begin
                evt  = hcs_pkg::EVT_HALL;
                ph   = track_any ? 2'($urandom_range(0, 2)) : track_ph;
                rise = track_any ? 1'($urandom_range(0, 1)) : track_rise;
            end
            else if (pick < 85)
            begin
                // Compare: the edge fields carry junk that must be ignored
                evt  = hcs_pkg::EVT_COMPARE;
                ph   = 2'($urandom_range(0, 3));
                rise = 1'($urandom_range(0, 1));
            end
            else
            begin
                evt  = hcs_pkg::EVT_HALL;
                ph   = 2'($urandom_range(0, 3));
                rise = 1'($urandom_range(0, 1));
            end
            send_word(evt, ph, rise, cap);
        end
    endtask

    initial
    begin
        logic [1:0]  mode_sel;
        logic [15:0] fint_sel;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings first, an illegal phase code and a compare
        send_word(hcs_pkg::EVT_HALL, hcs_pkg::PHASE_ANY, 1'b1, 16'hFFFF);
        send_word(hcs_pkg::EVT_COMPARE, hcs_pkg::PHASE_ANY, 1'b1, 16'hFFFF);
        wait_results_drained();

        // Automatic commutation round the full six steps, with wrong edges between
        program_regs(hcs_pkg::MODE_AUTO_FREE, 16'hFFFF);
        send_word(hcs_pkg::EVT_HALL, hcs_pkg::PHASE_U, 1'b1, 16'hFFFF);
        send_word(hcs_pkg::EVT_HALL, hcs_pkg::PHASE_W, 1'b1, 16'h5555);
        send_word(hcs_pkg::EVT_HALL, hcs_pkg::PHASE_V, 1'b0, 16'hAAAA);
        send_word(hcs_pkg::EVT_HALL, hcs_pkg::PHASE_W, 1'b0, 16'h0000);
        send_word(hcs_pkg::EVT_HALL, hcs_pkg::PHASE_V, 1'b1, 16'h1234);
        send_word(hcs_pkg::EVT_HALL, hcs_pkg::PHASE_U, 1'b0, 16'h0000);
        send_word(hcs_pkg::EVT_HALL, hcs_pkg::PHASE_W, 1'b1, 16'hFFFF);
        send_word(hcs_pkg::EVT_HALL, hcs_pkg::PHASE_V, 1'b0, 16'h8000);
        // Compare outside forced mode: the time moves, the step does not
        send_word(hcs_pkg::EVT_COMPARE, hcs_pkg::PHASE_V, 1'b0, 16'h0000);
        send_word(hcs_pkg::EVT_COMPARE, hcs_pkg::PHASE_W, 1'b1, 16'hFFFF);
        wait_results_drained();

        // Forced mode: step wraps past five and the compare time wraps too
        program_regs(hcs_pkg::MODE_FORCED, 16'h0001);
        repeat (7) send_word(hcs_pkg::EVT_COMPARE, hcs_pkg::PHASE_U, 1'b0, 16'h0000);
        // Edge outside an automatic mode: accepted, re-armed, no commutation
        send_word(hcs_pkg::EVT_HALL, hcs_pkg::PHASE_U, 1'b1, 16'h7FFF);
        wait_results_drained();

        program_regs(hcs_pkg::MODE_STOPPED, 16'h8001);
        send_word(hcs_pkg::EVT_HALL, hcs_pkg::PHASE_W, 1'b0, 16'h0001);
        send_word(hcs_pkg::EVT_COMPARE, hcs_pkg::PHASE_ANY, 1'b1, 16'hFFFF);
        wait_results_drained();

        program_regs(hcs_pkg::MODE_AUTO_PID, 16'h0000);
        send_word(hcs_pkg::EVT_HALL, hcs_pkg::PHASE_V, 1'b1, 16'hFFFE);
        send_word(hcs_pkg::EVT_HALL, hcs_pkg::PHASE_U, 1'b1, 16'h0002);
        send_word(hcs_pkg::EVT_HALL, hcs_pkg::PHASE_U, 1'b0, 16'h0002);
        wait_results_drained();

        // Random part: eight settings, cycling through the four idling profiles
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: begin mode_sel = hcs_pkg::MODE_STOPPED;   fint_sel = 16'h0000; end
                1: begin mode_sel = hcs_pkg::MODE_FORCED;    fint_sel = 16'hFFFF; end
                2: begin
                    mode_sel = hcs_pkg::MODE_AUTO_FREE;
                    fint_sel = 16'($urandom_range(0, 65535));
                end
                3: begin mode_sel = hcs_pkg::MODE_AUTO_PID;  fint_sel = 16'h0001; end
                4: begin
                    mode_sel = hcs_pkg::MODE_FORCED;
                    fint_sel = 16'($urandom_range(0, 65535));
                end
                5: begin mode_sel = hcs_pkg::MODE_AUTO_FREE; fint_sel = 16'h0000; end
                6: begin mode_sel = hcs_pkg::MODE_AUTO_PID;  fint_sel = 16'hFFFF; end
                default: begin mode_sel = hcs_pkg::MODE_FORCED; fint_sel = 16'h0001; end
            endcase
            program_regs(mode_sel, fint_sel);
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 70; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 70; end
                default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
            endcase
            if (p == 0)
                hold_tog = ~hold_tog;   // long receiver hold-off while words keep coming
            if (p == 2)
            begin
                // Pause the sender mid-run until everything has come back
                random_words(RANDOM_WORDS / 2);
                wait_results_drained();
                random_words(RANDOM_WORDS - RANDOM_WORDS / 2);
            end
            else
                random_words(RANDOM_WORDS);
            wait_results_drained();
        end

        // Let the block settle before the verdict
        repeat (4) @(posedge clk);

        $display("Covered %0d event words (edges, compares, stray edges) over eight settings",
                 words_sent);
        $display("of mode and force interval under four idling profiles; %0d results checked.",
                 checked);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: run timed out with %0d results outstanding", $time, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
sv/hcs_pkg.sv
sv/hcs_step.sv
sv/hall_commutation_sequencer.sv
tb/hcs_commutation_checker.sv
tb/tb.sv
